### rtl/ile_pkg.sv
// types, codes and sizing constants shared by the indexed list engine
// no dependencies
`default_nettype none

package ile_pkg;

    localparam int ILE_CAPACITY = 64;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         item_count;
        logic [1:0]         status;
    } out_item_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // open a slot at the position, later entries move up
        logic rem;    // close the slot at the position, later entries move down
        logic wr;     // overwrite the entry at the position
        logic snap;   // copy every entry into its read tap
        logic shift;  // move read taps one cell toward cell zero
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/ile_cell.sv
// one list slot: holds an element and a read tap, talks to its two neighbors
// depends on ile_pkg
`default_nettype none

module ile_cell
    import ile_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int POS_W = 7
) (
    input  wire logic               aclk,
    input  wire cell_cmd_t          cmd,
    input  wire logic [POS_W-1:0]   eff_pos,
    input  wire logic signed [31:0] value,
    input  wire logic signed [31:0] left_data,
    input  wire logic signed [31:0] right_data,
    input  wire logic signed [31:0] right_tap,
    output logic signed [31:0]      data,
    output logic signed [31:0]      tap
);

    logic signed [31:0] data_reg, data_next;
    logic signed [31:0] tap_reg, tap_next;
    logic               hit, above;

    assign hit   = (eff_pos == POS_W'(INDEX));
    assign above = (eff_pos < POS_W'(INDEX));

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (above) begin
                data_next = left_data;
            end else if (hit) begin
                data_next = value;
            end
        end else if (cmd.rem) begin
            if (above || hit) begin
                data_next = right_data;
            end
        end else if (cmd.wr && hit) begin
            data_next = value;
        end
    end

    always_comb begin
        tap_next = tap_reg;
        if (cmd.snap) begin
            tap_next = data_reg;
        end else if (cmd.shift) begin
            tap_next = right_tap;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

`default_nettype wire

### rtl/ile_ctrl.sv
// sequencer: request register, element count, status, read-out walk, result register
// depends on ile_pkg
`default_nettype none

module ile_ctrl
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int POS_W    = (CNT_W > 7) ? CNT_W : 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_result,
    input  wire logic signed [31:0] tap0,
    output cell_cmd_t               cmd,
    output logic [POS_W-1:0]        eff_pos,
    output logic signed [31:0]      value
);

    state_t state_reg, state_next;

    in_item_t             req_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           stat_reg, stat_next;
    logic                 rd_reg, rd_next;
    logic [6:0]           walk_reg, walk_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            out_reg, out_next;

    logic [POS_W-1:0]     pos_ext, cnt_ext;
    logic                 is_full, pos_above, pos_not_below;
    logic [1:0]           stat_calc;
    logic                 do_ins, do_rem, do_wr, needs_rd;
    logic                 s_fire, load_out;
    logic [CNT_W+6:0]     cnt_wide;

    assign pos_ext       = POS_W'(req_reg.position);
    assign cnt_ext       = POS_W'(count_reg);
    assign is_full       = (count_reg == CNT_W'(CAPACITY));
    assign pos_above     = (pos_ext > cnt_ext);
    assign pos_not_below = (pos_ext >= cnt_ext);

    // status and cell actions for the held request
    always_comb begin
        stat_calc = STAT_OK;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        do_wr     = 1'b0;
        needs_rd  = 1'b0;
        unique case (req_reg.op) inside
            OP_APPEND: begin
                if (is_full) begin
                    stat_calc = STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos_above) begin
                    stat_calc = STAT_RANGE;
                end else if (is_full) begin
                    stat_calc = STAT_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_READ, OP_REPLACE, OP_REMOVE: begin
                if (pos_not_below) begin
                    stat_calc = STAT_RANGE;
                end else begin
                    needs_rd = 1'b1;
                    do_wr    = (req_reg.op == OP_REPLACE);
                    do_rem   = (req_reg.op == OP_REMOVE);
                end
            end
            default: begin
            end
        endcase
    end

    assign s_fire   = s_valid && s_ready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (needs_rd && (req_reg.position != 7'd0)) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (walk_reg == 7'd1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: begin
                cmd.ins  = do_ins;
                cmd.rem  = do_rem;
                cmd.wr   = do_wr;
                cmd.snap = 1'b1;
            end
            ST_SHIFT: cmd.shift = 1'b1;
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign eff_pos = (req_reg.op == OP_APPEND) ? cnt_ext : pos_ext;
    assign value   = req_reg.value;

    // datapath registers
    always_comb begin
        count_next   = count_reg;
        stat_next    = stat_reg;
        rd_next      = rd_reg;
        walk_next    = walk_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_EXEC) begin
            stat_next = stat_calc;
            rd_next   = needs_rd;
            walk_next = req_reg.position;
            if (do_ins) begin
                count_next = count_reg + CNT_W'(1);
            end else if (do_rem) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        if (state_reg == ST_SHIFT) begin
            walk_next = walk_reg - 7'd1;
        end
        if (load_out) begin
            m_valid_next        = 1'b1;
            out_next.read_value = rd_reg ? tap0 : 32'sd0;
            out_next.item_count = cnt_wide[6:0];
            out_next.status     = stat_reg;
        end
    end

    assign cnt_wide = {7'd0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_item;
        end
        stat_reg <= stat_next;
        rd_reg   <= rd_next;
        walk_reg <= walk_next;
        out_reg  <= out_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

### rtl/indexed_list_engine_top.sv
// indexed list engine: sequencer plus a row of element cells
// depends on ile_pkg, ile_ctrl, ile_cell
`default_nettype none
// a request passes through the exec state, for a successful read, replace or remove at a
//   nonzero position the shift state (the read tap walks one cell per cycle to cell zero),
//   then the done state, where the result is registered; a new request is taken only in idle;
//   a stalled result holds the following request in the done state until it is taken
// reset (aresetn low, synchronous) empties the list and drops any pending result;
//   element cells hold stale data, which is never shown for an unwritten slot

module indexed_list_engine_top
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_result
);

    // count must hold the capacity itself; positions compare at the wider of count and port
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > 7) ? CNT_W : 7;

    cell_cmd_t          cmd;
    logic [POS_W-1:0]   eff_pos;
    logic signed [31:0] value;

    // element and tap outputs of every cell, one extra tap slot as the chain end
    logic signed [31:0] cell_data [CAPACITY];
    logic signed [31:0] cell_tap  [CAPACITY+1];

    // nothing shifts in past the last cell
    assign cell_tap[CAPACITY] = 32'sd0;

    // sequencer: holds the request, decides status, steers the cells, registers the result
    ile_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .POS_W    (POS_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .tap0     (cell_tap[0]),
        .cmd      (cmd),
        .eff_pos  (eff_pos),
        .value    (value)
    );

    // row of cells: insert pulls from the left neighbor, remove from the right,
    // the read tap chain moves toward cell zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0] left_d, right_d;

        if (i == 0) begin : g_first
            // cell zero is never above the position, its left input goes unused
            assign left_d = value;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            // the last slot keeps its own value on remove; it is past the count then
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ile_cell #(
            .INDEX (i),
            .POS_W (POS_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .eff_pos    (eff_pos),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .right_tap  (cell_tap[i+1]),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

endmodule

`default_nettype wire

### rtl/ile_checker.sv
// port-level checks on the indexed list engine, bound to the top level
// depends on ile_pkg and indexed_list_engine_top
`default_nettype none

module ile_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = ILE_CAPACITY
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_result
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("stalled result changed");

    // one request at a time: an input transfer closes the input side
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while request in flight");

    // failed requests return no element
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result.status == STAT_RANGE || m_result.status == STAT_FULL)
        |-> m_result.read_value == 32'sd0)
        else $error("failed request returned data");

    // a full report comes only from a list at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status == STAT_FULL |-> m_result.item_count == 7'(CAPACITY))
        else $error("full status with count below capacity");

endmodule

bind indexed_list_engine_top ile_checker #(
    .CAPACITY (CAPACITY)
) u_ile_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

`default_nettype wire
